@@ sv/stbs_pkg.sv @@
// shared types and constants for the sorted table search block
`default_nettype none

package stbs_pkg;

    // fixed field widths
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 10;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_COMPARE = 2'd1;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // item classes decided by the front
    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SKIP   = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_EMPTY  = 2'd3
    } stbs_kind_t;

    // one queued item
    typedef struct packed {
        stbs_kind_t           kind;
        logic [COUNT_W-1:0]   count;
        logic                 signed_cmp;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   value;
    } stbs_item_t;

endpackage

`default_nettype wire

@@ sv/stbs_front.sv @@
// front part: accepts items and classifies them for the back part
`default_nettype none

module stbs_front
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               start,
    input  wire logic               operation,
    input  wire logic [INDEX_W-1:0] index,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [COUNT_W-1:0] entry_count,
    input  wire logic               signed_compare,
    input  wire logic               queue_full,
    output logic                    busy,
    output logic                    push,
    output stbs_item_t              item
);

    logic               in_range;
    logic [COUNT_W-1:0] count_sat;

    // accept while the queue has room
    assign busy = queue_full;
    assign push = start && !queue_full;

    // write index check and saturated entry count
    assign in_range  = 32'(index) < TABLE_DEPTH;
    assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : entry_count;

    // classify the item
    always_comb
    begin
        item.count      = count_sat;
        item.signed_cmp = signed_compare;
        item.index      = index;
        item.value      = value;
        if (operation == OP_WRITE)
        begin
            item.kind = in_range ? KIND_WRITE : KIND_SKIP;
        end
        else
        begin
            item.kind = (entry_count == '0) ? KIND_EMPTY : KIND_SEARCH;
        end
    end

endmodule

`default_nettype wire

@@ sv/stbs_queue.sv @@
// short item queue between front and back
`default_nettype none

module stbs_queue
    import stbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire stbs_item_t push_item,
    input  wire logic       pop,
    output stbs_item_t      head,
    output logic            full,
    output logic            empty
);

    stbs_item_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ sv/stbs_back.sv @@
// back part: key table memory and the search sequencer
`default_nettype none

module stbs_back
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stbs_item_t       head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  done,
    output logic                  found,
    output logic [POS_W-1:0]      position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    logic [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   bot_reg, bot_next;
    logic [COUNT_W-1:0]   span_reg, span_next;
    logic [KEY_WIDTH-1:0] kc_reg, kc_next;
    logic                 signed_reg, signed_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [POS_W-1:0]     position_reg, position_next;

    logic [KEY_WIDTH-1:0] head_key;
    logic [KEY_WIDTH-1:0] head_code;
    logic [KEY_WIDTH-1:0] entry_code;
    logic [KEY_WIDTH-1:0] sign_bit;
    logic [COUNT_W-1:0]   half;
    logic [COUNT_W-1:0]   span_rest;
    logic [COUNT_W-1:0]   half_rest;
    logic [COUNT_W-1:0]   bot_up;
    logic                 key_ge;
    logic                 key_eq;
    logic                 mem_we;
    logic [COUNT_W-1:0]   rd_addr;

    // order-preserving codes for the key and the fetched entry
    assign sign_bit   = {1'b1, (KEY_WIDTH-1)'(0)};
    assign head_key   = KEY_WIDTH'(head.value);
    assign head_code  = head.signed_cmp ? (head_key ^ sign_bit) : head_key;
    assign entry_code = signed_reg ? (rd_data_reg ^ sign_bit) : rd_data_reg;
    assign key_ge     = kc_reg >= entry_code;
    assign key_eq     = kc_reg == entry_code;

    // one halving round
    assign half      = span_reg >> 1;
    assign span_rest = span_reg - half;
    assign half_rest = span_rest >> 1;
    assign bot_up    = bot_reg + half;

    assign pop = (state_reg == ST_IDLE) && !empty;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        bot_next      = bot_reg;
        span_next     = span_reg;
        kc_next       = kc_reg;
        signed_next   = signed_reg;
        done_next     = 1'b0;
        found_next    = 1'b0;
        position_next = '0;
        mem_we        = 1'b0;
        rd_addr       = bot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = head.count >> 1;
                if (!empty)
                begin
                    unique case (head.kind)
                        KIND_WRITE:
                        begin
                            mem_we = 1'b1;
                        end
                        KIND_EMPTY:
                        begin
                            done_next = 1'b1;
                        end
                        KIND_SEARCH:
                        begin
                            bot_next    = '0;
                            span_next   = head.count;
                            kc_next     = head_code;
                            signed_next = head.signed_cmp;
                            state_next  = ST_RUN;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (span_reg > COUNT_W'(1))
                begin
                    bot_next  = key_ge ? bot_up : bot_reg;
                    span_next = span_rest;
                    rd_addr   = key_ge ? (bot_up + half_rest) : (bot_reg + half_rest);
                end
                else
                begin
                    // final equality test on the bottom entry
                    done_next     = 1'b1;
                    found_next    = key_eq;
                    position_next = key_eq ? POS_W'(bot_reg) : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bot_reg      <= bot_next;
        span_reg     <= span_next;
        kc_reg       <= kc_next;
        signed_reg   <= signed_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    // key table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ADDR_W'(head.index)] <= head_key;
        end
        rd_data_reg <= mem[ADDR_W'(rd_addr)];
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = position_reg;

endmodule

`default_nettype wire

@@ sv/sorted_table_binary_search_top.sv @@
// top level of the sorted key table with mono-bound binary search
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-------------------------------
//  command   | start in, busy out          | operation, index, value
//  result    | done out (one-cycle strobe) | found, position
//  config    | cfg_valid in, cfg_ready out | cfg_index, cfg_data
//
// a search of n entries runs the search sequencer through an issue step, one memory
// probe per halving round and a final compare; a write is performed from the idle
// state without leaving it; done is registered after the final compare
// a two-item queue lets commands be taken while a search runs; busy is high when it is full
// reset clears control and configuration; the key table holds no reset value
// the result receiver cannot stall, so done is never held off
`default_nettype none

module sorted_table_binary_search_top
    import stbs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 operation,
    input  wire logic [INDEX_W-1:0]   index,
    input  wire logic [VALUE_W-1:0]   value,
    output logic                      done,
    output logic                      found,
    output logic [POS_W-1:0]          position,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COUNT_W-1:0]   cfg_data
);

    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic               signed_compare_reg, signed_compare_next;

    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;
    stbs_item_t push_item;
    stbs_item_t head;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        entry_count_next    = entry_count_reg;
        signed_compare_next = signed_compare_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT:    entry_count_next    = cfg_data;
                CFG_SIGNED_COMPARE: signed_compare_next = cfg_data[0];
                default:            entry_count_next    = entry_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            signed_compare_reg <= 1'b0;
        end
        else
        begin
            entry_count_reg    <= entry_count_next;
            signed_compare_reg <= signed_compare_next;
        end
    end

    // front: accept and classify
    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .start          (start),
        .operation      (operation),
        .index          (index),
        .value          (value),
        .entry_count    (entry_count_reg),
        .signed_compare (signed_compare_reg),
        .queue_full     (queue_full),
        .busy           (busy),
        .push           (push),
        .item           (push_item)
    );

    // item queue
    stbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: table and search
    stbs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (queue_empty),
        .pop      (pop),
        .done     (done),
        .found    (found),
        .position (position)
    );

    // result fields are quiet between strobes
    a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (!found && position == '0))
        else $error("result fields active without done");

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> position == '0)
        else $error("miss reported with nonzero position");

    // busy only rises after an accepted command
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted command");

    // nothing is popped from an empty queue
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ tb/sv/tb_sorted_table_binary_search_top.sv @@
// self-checking testbench for the sorted key table with mono-bound binary search
module tb_sorted_table_binary_search_top;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH  = 1024;
    localparam int KEY_WIDTH    = 32;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 48;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int CALM_ITEMS   = 160;
    localparam logic [VALUE_W-1:0] SIGN_BIT = {1'b1, {(VALUE_W-1){1'b0}}};
    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
    } table_cmd_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } lookup_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // block ports
    logic                 start     = 1'b0;
    logic                 operation = OP_WRITE;
    logic [INDEX_W-1:0]   index     = '0;
    logic [VALUE_W-1:0]   value     = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ENTRY_COUNT;
    logic [COUNT_W-1:0]   cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic                 found;
    logic [POS_W-1:0]     position;
    logic                 cfg_ready;

    // predictor copy of the block state
    logic [VALUE_W-1:0] mirror_keys [TABLE_DEPTH];
    logic [COUNT_W-1:0] mirror_count  = '0;
    logic               mirror_signed = 1'b0;

    // stimulus side view of the table, used to pick keys
    logic [VALUE_W-1:0] plan_keys [TABLE_DEPTH];

    table_cmd_t cmd_backlog [$];
    lookup_t    lookup_due [$];
    int         queued_total = 0;
    int         taken_total  = 0;
    int         fail_count   = 0;
    int         hold_off     = 0;
    int         stall_cycles = 0;
    bit         idle_on      = 1'b1;

    sorted_table_binary_search_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .index     (index),
        .value     (value),
        .done      (done),
        .found     (found),
        .position  (position),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mono-bound search over the mirrored table, last entry of a run of equals
    function automatic lookup_t lookup_last_match(input logic [VALUE_W-1:0] key);
        lookup_t            res;
        logic [VALUE_W-1:0] flip;
        int                 n;
        int                 lo;
        int                 span;
        int                 half;
        res.found    = 1'b0;
        res.position = '0;
        n = (mirror_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(mirror_count);
        if (n == 0)
            return res;
        flip = mirror_signed ? SIGN_BIT : '0;
        lo   = 0;
        span = n;
        while (span > 1)
        begin
            half = span >> 1;
            if ((key ^ flip) >= (mirror_keys[lo + half] ^ flip))
                lo += half;
            span -= half;
        end
        if (key == mirror_keys[lo])
        begin
            res.found    = 1'b1;
            res.position = lo[POS_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        fail_count++;
    endtask

    // command driver: takes items from the backlog, with random hold-off bursts
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        table_cmd_t nxt;
        if (!rst_n)
        begin
            start     <= 1'b0;
            operation <= OP_WRITE;
            index     <= '0;
            value     <= '0;
        end
        else
        begin
            // item taken at this edge: update the mirror or predict the lookup
            if (start && !busy)
            begin
                if (operation == OP_SEARCH)
                    lookup_due.push_back(lookup_last_match(value));
                else
                    mirror_keys[index] = value;
                taken_total++;
            end
            if (!start || !busy)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    nxt = cmd_backlog.pop_front();
                    start     <= 1'b1;
                    operation <= nxt.op;
                    index     <= nxt.idx;
                    value     <= nxt.val;
                    if (idle_on && $urandom_range(0, 4) == 0)
                        hold_off = $urandom_range(1, 17);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n && done)
        begin
            if (lookup_due.size() == 0)
                report_mismatch("result with no lookup pending", 32'd0,
                                32'({found, position}));
            else
            begin
                want = lookup_due.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(found));
                if (position !== want.position)
                    report_mismatch("position", 32'(want.position), 32'(position));
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_sorted_table_binary_search_top NOT OK");
                $finish;
            end
        end
    end

    task automatic queue_write(input int idx, input logic [VALUE_W-1:0] val);
        table_cmd_t cmd;
        cmd.op  = OP_WRITE;
        cmd.idx = idx[INDEX_W-1:0];
        cmd.val = val;
        cmd_backlog.push_back(cmd);
        plan_keys[idx] = val;
        queued_total++;
    endtask

    task automatic queue_search(input logic [VALUE_W-1:0] val);
        table_cmd_t cmd;
        logic [31:0] junk;
        junk    = $urandom;
        cmd.op  = OP_SEARCH;
        cmd.idx = junk[INDEX_W-1:0];
        cmd.val = val;
        cmd_backlog.push_back(cmd);
        queued_total++;
    endtask

    // wait until every item is taken and every lookup answered, then let writes finish
    task automatic quiesce();
        while (taken_total != queued_total || lookup_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [COUNT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (sel == CFG_ENTRY_COUNT)
            mirror_count = data;
        else if (sel == CFG_SIGNED_COMPARE)
            mirror_signed = data[0];
        cfg_valid <= 1'b0;
    endtask

    // one setting: program the registers, optionally load a sorted table, then look up
    task automatic run_phase(input int count, input bit sgn, input bit refill,
                             input int lookups);
        logic [VALUE_W-1:0] codes [TABLE_DEPTH];
        logic [VALUE_W-1:0] flip;
        logic [VALUE_W-1:0] probe;
        logic [VALUE_W-1:0] pick;
        logic [31:0]        junk;
        int                 n;
        int                 off;
        int                 j;
        int                 r;
        n    = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        flip = sgn ? SIGN_BIT : '0;
        quiesce();
        junk = $urandom;
        write_reg(CFG_ENTRY_COUNT, count[COUNT_W-1:0]);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_SIGNED_COMPARE, {junk[COUNT_W-2:0], sgn});
        else
            write_reg(CFG_SIGNED_COMPARE, {{(COUNT_W-1){1'b0}}, sgn});
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      junk[COUNT_W+10:11]);

        // sorted order codes with runs of equal keys, written in rotated order
        if (refill && n > 0)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (i > 0 && $urandom_range(0, 3) == 0)
                    codes[i] = codes[i-1];
                else if ($urandom_range(0, 11) == 0)
                    codes[i] = $urandom_range(0, 1) ? '1 : '0;
                else
                    codes[i] = $urandom;
            end
            for (int i = 1; i < n; i++)
            begin
                probe = codes[i];
                j = i - 1;
                while (j >= 0 && codes[j] > probe)
                begin
                    codes[j+1] = codes[j];
                    j--;
                end
                codes[j+1] = probe;
            end
            off = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++)
            begin
                j = (i + off) % n;
                queue_write(j, codes[j] ^ flip);
            end
        end

        // lookups, mostly of stored keys, with stray writes mixed in
        for (int k = 0; k < lookups; k++)
        begin
            r    = $urandom_range(0, 99);
            pick = (n > 0) ? plan_keys[$urandom_range(0, n - 1)] : $urandom;
            if (r < 55)
                queue_search(pick);
            else if (r < 70)
                queue_search(r[0] ? pick + 1'b1 : pick - 1'b1);
            else if (r < 80)
            begin
                case ($urandom_range(0, 3))
                    0:       queue_search('0);
                    1:       queue_search('1);
                    2:       queue_search(SIGN_BIT);
                    default: queue_search(~SIGN_BIT);
                endcase
            end
            else if (r < 90)
                queue_search($urandom);
            else if (r < 97 && n < TABLE_DEPTH)
                queue_write($urandom_range(n, TABLE_DEPTH - 1), $urandom);
            else if (n > 0)
                queue_write($urandom_range(0, n - 1), $urandom);
            else
                queue_search($urandom);
        end
    endtask

    // stimulus sequence
    initial
    begin : stimulus
        int  base;
        bit  big_done;
        int  pick;
        int  n;
        bit  sgn;
        big_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty table straight out of reset
        queue_search('0);

        // small unsigned table with a run of equal keys and both extremes
        queue_write(0, 32'd5);
        queue_write(1, 32'd5);
        queue_write(2, SIGN_BIT);
        queue_write(3, '1);
        queue_write(TABLE_DEPTH - 1, '1);
        quiesce();
        write_reg(CFG_ENTRY_COUNT, 11'd4);
        queue_search(32'd5);
        queue_search('0);
        queue_search('1);
        queue_search(SIGN_BIT);
        queue_search(32'd6);
        queue_search(~SIGN_BIT);

        // same table seen as signed, so out of order
        quiesce();
        write_reg(CFG_SIGNED_COMPARE, 11'd1);
        queue_search('1);
        queue_search(32'd5);
        queue_search(SIGN_BIT);

        // single entry, then empty again by register
        quiesce();
        write_reg(CFG_ENTRY_COUNT, 11'd1);
        queue_search(32'd5);
        queue_search(32'd4);
        quiesce();
        write_reg(CFG_ENTRY_COUNT, 11'd0);
        queue_search(32'd5);

        // signed table in proper order
        queue_write(0, SIGN_BIT);
        queue_write(1, '1);
        queue_write(2, '0);
        queue_write(3, ~SIGN_BIT);
        quiesce();
        write_reg(CFG_ENTRY_COUNT, 11'd4);
        queue_search(SIGN_BIT);
        queue_search(~SIGN_BIT);
        queue_search(32'd1);

        // random settings, with one full table and counts past its depth
        base = queued_total;
        while (queued_total - base < RANDOM_ITEMS)
        begin
            idle_on = (RANDOM_ITEMS - (queued_total - base) < CALM_ITEMS) ? 1'b0 :
                      ($urandom_range(0, 3) != 0);
            sgn = 1'($urandom_range(0, 1));
            if (!big_done && queued_total - base > 250)
            begin
                run_phase(TABLE_DEPTH, sgn, 1'b1, 80);
                run_phase((1 << COUNT_W) - 1, 1'($urandom_range(0, 1)), 1'b0, 40);
                run_phase($urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 2), sgn, 1'b0, 20);
                big_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    run_phase(0, sgn, 1'b0, 8);
                else
                begin
                    n = (pick == 1) ? 1 : $urandom_range(2, 24);
                    run_phase(n, sgn, 1'b1, $urandom_range(10, 30));
                end
            end
        end

        quiesce();
        if (fail_count == 0)
            $display("tb_sorted_table_binary_search_top OK");
        else
            $display("tb_sorted_table_binary_search_top NOT OK");
        $finish;
    end

endmodule
